[rtl/core/acps_pkg.sv]
// Shared types, constants and register indexes for the circle pixel shader.
`timescale 1ns / 1ps

package acps_pkg;

    // Frame size defaults
    localparam int FRAME_WIDTH_DEF  = 1024;
    localparam int FRAME_HEIGHT_DEF = 1024;

    // Field widths
    localparam int COORD_W = 11;
    localparam int CENTER_W = 16;
    localparam int RADIUS_W = 14;
    localparam int COLOR_W = 8;
    localparam int SOFT_W = 12;
    localparam int ALPHA_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Arithmetic widths
    localparam int MAG_W = 16;                  // |dx|, |dy|
    localparam int SQ_W = 2 * MAG_W;            // dx^2, dy^2
    localparam int RSQ_W = 2 * RADIUS_W;        // radius^2 and positive margin
    localparam int NUM_W = RSQ_W + 4;           // margin * 16
    localparam int DIV_W = SOFT_W + 8;          // 255 * softness
    localparam int QUOT_W = 8;                  // quotient bits below saturation
    localparam int REM_W = DIV_W + QUOT_W;      // remainder width once below 256*div

    // Full coverage value
    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 9'd256;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_R   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_G   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_B   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT     = 3'd6;

    localparam logic [SOFT_W-1:0] SOFT_RESET = 12'd16;

    // Old pixel bytes carried down the pipe
    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_pix;

    // Divider pipe bus: partial remainder, quotient so far, saturation and pixel
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [QUOT_W-1:0] quot;
        logic              sat;
        t_pix              pix;
    } t_div_bus;

endpackage

[rtl/core/acps_dist_lane.sv]
// One axis lane: offset from the circle center and its registered square.
`timescale 1ns / 1ps

module acps_dist_lane (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [acps_pkg::COORD_W-1:0]           i_coord,
    input  logic signed [acps_pkg::CENTER_W-1:0]   i_center,
    output logic [acps_pkg::SQ_W-1:0]              o_sq
);

    localparam int DIFF_W = acps_pkg::COORD_W + 4 + 2;

    logic signed [DIFF_W-1:0]       w_diff;
    logic [DIFF_W-1:0]              w_abs;
    logic [acps_pkg::MAG_W-1:0]     w_mag;
    logic [acps_pkg::SQ_W-1:0]      r_sq;

    // Offset in 1/16 pixel and its magnitude
    assign w_diff = signed'({2'b00, i_coord, 4'b0000})
                  - DIFF_W'(i_center);
    assign w_abs  = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);
    assign w_mag  = w_abs[acps_pkg::MAG_W-1:0];

    // Square and hold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= w_mag * w_mag;
        end
    end

    assign o_sq = r_sq;

endmodule

[rtl/core/acps_div_step.sv]
// One restoring division step: retires a single quotient bit per stage.
`timescale 1ns / 1ps

module acps_div_step #(
    parameter int SHIFT = 7
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [acps_pkg::DIV_W-1:0]        i_div,
    input  acps_pkg::t_div_bus                i_bus,
    output acps_pkg::t_div_bus                o_bus
);

    logic [acps_pkg::REM_W-1:0] w_trial;
    logic                       w_take;
    acps_pkg::t_div_bus         n_bus;
    acps_pkg::t_div_bus         r_bus;

    // Compare against the shifted divisor and subtract when it fits
    assign w_trial = acps_pkg::REM_W'(i_div) << SHIFT;
    assign w_take  = i_bus.rem >= w_trial;

    always_comb begin
        n_bus = i_bus;
        if (w_take) begin
            n_bus.rem         = i_bus.rem - w_trial;
            n_bus.quot[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

[rtl/core/acps_blend_lane.sv]
// One color channel lane: mixes the old byte with the fill byte by coverage.
`timescale 1ns / 1ps

module acps_blend_lane (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [acps_pkg::COLOR_W-1:0]       i_old,
    input  logic [acps_pkg::COLOR_W-1:0]       i_fill,
    input  logic [acps_pkg::ALPHA_W-1:0]       i_alpha,
    output logic [acps_pkg::COLOR_W-1:0]       o_new
);

    localparam int PROD_W = acps_pkg::COLOR_W + acps_pkg::ALPHA_W;

    logic [acps_pkg::ALPHA_W-1:0] w_inv;
    logic [PROD_W-1:0]            w_sum;
    logic [acps_pkg::COLOR_W-1:0] r_new;

    // Weighted sum stays below 2^16, so the byte is bits 15:8
    assign w_inv = acps_pkg::ALPHA_FULL - i_alpha;
    assign w_sum = PROD_W'(i_old * w_inv) + PROD_W'(i_fill * i_alpha);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_new <= w_sum[2*acps_pkg::COLOR_W-1:acps_pkg::COLOR_W];
        end
    end

    assign o_new = r_new;

endmodule

[rtl/core/antialiased_circle_pixel_shader.sv]
// Top level of the anti-aliased circle pixel shader: config, pipeline control, merge.
//
//  channel   direction  handshake                    payload
//  pixel in  input      i_in_valid / o_in_ready      i_pixel_x, i_pixel_y, i_old_*
//  pixel out output     o_out_valid / i_out_ready    o_new_*, o_coverage
//  config    input      i_cfg_we                     i_cfg_idx, i_cfg_data
//
//  One item per clock while the output is not stalled, through 12 register stages: squares,
//  margin, saturation check, eight restoring divide steps (one quotient bit each), blend.
//  Reset clears the stage valid bits and sets the configuration registers to their defaults.
//  A stalled output fills bubbles first; o_in_ready drops only when all stages hold items.
`timescale 1ns / 1ps

module antialiased_circle_pixel_shader #(
    parameter int FRAME_WIDTH  = acps_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = acps_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Config port
    input  logic                                 i_cfg_we,
    input  logic [acps_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [acps_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Pixel in
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [acps_pkg::COORD_W-1:0]         i_pixel_x,
    input  logic [acps_pkg::COORD_W-1:0]         i_pixel_y,
    input  logic [acps_pkg::COLOR_W-1:0]         i_old_blue,
    input  logic [acps_pkg::COLOR_W-1:0]         i_old_green,
    input  logic [acps_pkg::COLOR_W-1:0]         i_old_red,
    // Pixel out
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [acps_pkg::COLOR_W-1:0]         o_new_blue,
    output logic [acps_pkg::COLOR_W-1:0]         o_new_green,
    output logic [acps_pkg::COLOR_W-1:0]         o_new_red,
    output logic [acps_pkg::ALPHA_W-1:0]         o_coverage
);

    localparam int NSTG     = 3 + acps_pkg::QUOT_W + 1;
    localparam int DIV_BASE = 3;
    localparam int BLEND    = NSTG - 1;
    localparam int CMP_W    = acps_pkg::COORD_W + 1;

    // Configuration registers
    logic signed [acps_pkg::CENTER_W-1:0] r_center_x;
    logic signed [acps_pkg::CENTER_W-1:0] r_center_y;
    logic [acps_pkg::RADIUS_W-1:0]        r_radius;
    logic [acps_pkg::COLOR_W-1:0]         r_fill_red;
    logic [acps_pkg::COLOR_W-1:0]         r_fill_green;
    logic [acps_pkg::COLOR_W-1:0]         r_fill_blue;
    logic [acps_pkg::SOFT_W-1:0]          r_soft;

    // Pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    // Stage 0: squares and pixel bytes
    logic [acps_pkg::SQ_W-1:0] w_sq_x;
    logic [acps_pkg::SQ_W-1:0] w_sq_y;
    logic                      r_s0_inframe;
    acps_pkg::t_pix            r_s0_pix;
    logic                      w_inframe;

    // Stage 1: scaled margin
    logic [acps_pkg::SQ_W:0]     w_sum;
    logic [acps_pkg::RSQ_W-1:0]  w_rad_sq;
    logic [acps_pkg::RSQ_W-1:0]  w_margin;
    logic                        w_pos;
    logic [acps_pkg::NUM_W-1:0]  r_s1_num;
    acps_pkg::t_pix              r_s1_pix;

    // Stage 2 onward: divider bus
    logic [acps_pkg::SOFT_W-1:0] w_soft;
    logic [acps_pkg::DIV_W-1:0]  w_div;
    logic                        w_sat;
    acps_pkg::t_div_bus          r_s2_bus;
    acps_pkg::t_div_bus          w_div_bus [acps_pkg::QUOT_W+1];

    // Merge stage
    logic [acps_pkg::ALPHA_W-1:0] w_alpha;
    logic [acps_pkg::ALPHA_W-1:0] r_coverage;
    acps_pkg::t_div_bus           w_last;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_radius     <= '0;
            r_fill_red   <= '0;
            r_fill_green <= '0;
            r_fill_blue  <= '0;
            r_soft       <= acps_pkg::SOFT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                acps_pkg::CFG_CENTER_X: r_center_x <= signed'(i_cfg_data);
                acps_pkg::CFG_CENTER_Y: r_center_y <= signed'(i_cfg_data);
                acps_pkg::CFG_RADIUS:   r_radius <= i_cfg_data[acps_pkg::RADIUS_W-1:0];
                acps_pkg::CFG_FILL_R:   r_fill_red <= i_cfg_data[acps_pkg::COLOR_W-1:0];
                acps_pkg::CFG_FILL_G:   r_fill_green <= i_cfg_data[acps_pkg::COLOR_W-1:0];
                acps_pkg::CFG_FILL_B:   r_fill_blue <= i_cfg_data[acps_pkg::COLOR_W-1:0];
                acps_pkg::CFG_SOFT:     r_soft <= i_cfg_data[acps_pkg::SOFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance a stage when it is empty or the next one advances
    assign w_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
    generate
        for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
            assign w_en[k] = !r_vld[k] || w_en[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready = w_en[0];

    // Stage 0: one square lane per axis
    acps_dist_lane u_lane_x (
        .i_clk    (i_clk),
        .i_en     (w_en[0]),
        .i_coord  (i_pixel_x),
        .i_center (r_center_x),
        .o_sq     (w_sq_x)
    );

    acps_dist_lane u_lane_y (
        .i_clk    (i_clk),
        .i_en     (w_en[0]),
        .i_coord  (i_pixel_y),
        .i_center (r_center_y),
        .o_sq     (w_sq_y)
    );

    assign w_inframe = ({1'b0, i_pixel_x} < CMP_W'(FRAME_WIDTH))
                    && ({1'b0, i_pixel_y} < CMP_W'(FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_inframe   <= w_inframe;
            r_s0_pix.blue  <= i_old_blue;
            r_s0_pix.green <= i_old_green;
            r_s0_pix.red   <= i_old_red;
        end
    end

    // Stage 1: margin inside the circle, zero when outside or off frame
    assign w_rad_sq = r_radius * r_radius;
    assign w_sum    = {1'b0, w_sq_x} + {1'b0, w_sq_y};
    assign w_pos    = r_s0_inframe && (w_sum < (acps_pkg::SQ_W+1)'(w_rad_sq));
    assign w_margin = w_rad_sq - w_sum[acps_pkg::RSQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_num <= w_pos ? {w_margin, 4'b0000} : '0;
            r_s1_pix <= r_s0_pix;
        end
    end

    // Stage 2: divisor 255*softness and saturation at full coverage
    assign w_soft = (r_soft == '0) ? acps_pkg::SOFT_W'(1) : r_soft;
    assign w_div  = {w_soft, 8'b0000_0000} - acps_pkg::DIV_W'(w_soft);
    assign w_sat  = r_s1_num >= (acps_pkg::NUM_W'(w_div) << acps_pkg::QUOT_W);

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_bus.rem  <= r_s1_num[acps_pkg::REM_W-1:0];
            r_s2_bus.quot <= '0;
            r_s2_bus.sat  <= w_sat;
            r_s2_bus.pix  <= r_s1_pix;
        end
    end

    // Stages 3..10: one quotient bit per stage, high bit first
    assign w_div_bus[0] = r_s2_bus;
    generate
        for (genvar j = 0; j < acps_pkg::QUOT_W; j++) begin : g_div
            acps_div_step #(
                .SHIFT (acps_pkg::QUOT_W - 1 - j)
            ) u_step (
                .i_clk (i_clk),
                .i_en  (w_en[DIV_BASE+j]),
                .i_div (w_div),
                .i_bus (w_div_bus[j]),
                .o_bus (w_div_bus[j+1])
            );
        end
    endgenerate

    // Merge: pick coverage and blend the three channels
    assign w_last  = w_div_bus[acps_pkg::QUOT_W];
    assign w_alpha = w_last.sat ? acps_pkg::ALPHA_FULL
                                : acps_pkg::ALPHA_W'(w_last.quot);

    acps_blend_lane u_blend_b (
        .i_clk   (i_clk),
        .i_en    (w_en[BLEND]),
        .i_old   (w_last.pix.blue),
        .i_fill  (r_fill_blue),
        .i_alpha (w_alpha),
        .o_new   (o_new_blue)
    );

    acps_blend_lane u_blend_g (
        .i_clk   (i_clk),
        .i_en    (w_en[BLEND]),
        .i_old   (w_last.pix.green),
        .i_fill  (r_fill_green),
        .i_alpha (w_alpha),
        .o_new   (o_new_green)
    );

    acps_blend_lane u_blend_r (
        .i_clk   (i_clk),
        .i_en    (w_en[BLEND]),
        .i_old   (w_last.pix.red),
        .i_fill  (r_fill_red),
        .i_alpha (w_alpha),
        .o_new   (o_new_red)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[BLEND]) begin
            r_coverage <= w_alpha;
        end
    end

    assign o_coverage  = r_coverage;
    assign o_out_valid = r_vld[NSTG-1];

    // Input stalls only when every stage holds an item
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> &r_vld)
        else $error("input stalled with a bubble in the pipe");

    // Coverage never exceeds full
    a_cov_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_coverage <= acps_pkg::ALPHA_FULL))
        else $error("coverage above full");

    // Full coverage gives the fill color
    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_coverage == acps_pkg::ALPHA_FULL)) |->
        ((o_new_red == r_fill_red) && (o_new_green == r_fill_green)
         && (o_new_blue == r_fill_blue)))
        else $error("full coverage without fill color");

    // An item in the last divide stage moves into the merge stage when it advances
    a_item_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[BLEND-1] && w_en[BLEND]) |=> r_vld[BLEND])
        else $error("item lost entering the merge stage");

endmodule
